// ----- hw/rtl/pedestrian_crossing_sequencer_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Pedestrian crossing sequencer - assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PEDESTRIAN_CROSSING_SEQUENCER_UNIT_MACROS_SVH
`define PEDESTRIAN_CROSSING_SEQUENCER_UNIT_MACROS_SVH

// Same-cycle implication.
`define PCS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PCS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/pcs_pkg.sv -----
// ----------------------------------------------------------------------------
// Pedestrian crossing sequencer - package
// Phase codes, register indexes, counter width and shared types.
// ----------------------------------------------------------------------------
package pcs_pkg;

    localparam int COUNTER_BITS = 8;
    localparam int LEN_W        = (COUNTER_BITS > 9) ? COUNTER_BITS : 9;
    localparam int NUM_PHASES   = 6;

    localparam logic [COUNTER_BITS-1:0] CNT_MAX = {COUNTER_BITS{1'b1}};

    // Phase codes
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_PRE   = 3'd1;
    localparam logic [2:0] PH_BLINK = 3'd2;
    localparam logic [2:0] PH_CLOSE = 3'd3;
    localparam logic [2:0] PH_HOLD  = 3'd4;
    localparam logic [2:0] PH_OPEN  = 3'd5;

    // Configuration register indexes
    localparam logic [2:0] REG_PRE_DELAY = 3'd0;
    localparam logic [2:0] REG_BLINK     = 3'd1;
    localparam logic [2:0] REG_CLOSE     = 3'd2;
    localparam logic [2:0] REG_HOLD      = 3'd3;
    localparam logic [2:0] REG_OPEN      = 3'd4;

    typedef logic [COUNTER_BITS-1:0] cnt_t;

    // Phase lengths in ticks, already clamped to the counter range
    typedef struct packed {
        cnt_t pre_len;
        cnt_t blink_len;
        cnt_t close_len;
        cnt_t hold_len;
        cnt_t open_len;
    } pcs_len_t;

    typedef struct packed {
        logic       green_lamp;
        logic       orange_lamp;
        logic       red_lamp;
        logic       motor_close;
        logic       motor_open;
        logic [2:0] phase;
    } pcs_result_t;

    function automatic cnt_t clamp_len(input logic [LEN_W-1:0] n);
        cnt_t r;
        if (n > LEN_W'(CNT_MAX))
            r = CNT_MAX;
        else
            r = n[COUNTER_BITS-1:0];
        return r;
    endfunction

endpackage

// ----- hw/rtl/pcs_cfg.sv -----
// ----------------------------------------------------------------------------
// Pedestrian crossing sequencer - configuration registers
// Holds the five phase settings and presents them as clamped tick lengths.
// ----------------------------------------------------------------------------
module pcs_cfg
    import pcs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data,
    output pcs_len_t   lens
);

    logic [7:0] pre_reg;
    logic [3:0] blink_reg;
    logic [7:0] close_reg;
    logic [7:0] hold_reg;
    logic [7:0] open_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_reg   <= 8'd5;
            blink_reg <= 4'd5;
            close_reg <= 8'd10;
            hold_reg  <= 8'd15;
            open_reg  <= 8'd10;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_PRE_DELAY: pre_reg   <= cfg_data;
                REG_BLINK:     blink_reg <= cfg_data[3:0];
                REG_CLOSE:     close_reg <= cfg_data;
                REG_HOLD:      hold_reg  <= cfg_data;
                REG_OPEN:      open_reg  <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Each blink cycle is one tick on and one tick off
    always_comb
    begin
        lens.pre_len   = clamp_len(LEN_W'(pre_reg));
        lens.blink_len = clamp_len(LEN_W'({blink_reg, 1'b0}));
        lens.close_len = clamp_len(LEN_W'(close_reg));
        lens.hold_len  = clamp_len(LEN_W'(hold_reg));
        lens.open_len  = clamp_len(LEN_W'(open_reg));
    end

endmodule

// ----- hw/rtl/pcs_core.sv -----
// ----------------------------------------------------------------------------
// Pedestrian crossing sequencer - phase engine
// Request latch, phase register and tick counter; one update per accepted item.
// ----------------------------------------------------------------------------
`include "pedestrian_crossing_sequencer_unit_macros.svh"

module pcs_core
    import pcs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_acc,
    input  logic        button_press,
    input  logic        second_tick,
    input  pcs_len_t    lens,
    output pcs_result_t result
);

    logic [2:0] phase_reg;
    logic [2:0] phase_next;
    cnt_t       cnt_reg;
    cnt_t       cnt_next;
    logic       req_reg;
    logic       req_next;

    logic [2:0] cur_phase;
    cnt_t       cur_cnt;
    cnt_t       dec_cnt;
    cnt_t       cnt_upd;
    logic       do_enter;
    logic [2:0] start_phase;
    logic [2:0] sel_phase;
    cnt_t       sel_len;
    cnt_t       len_arr [0:NUM_PHASES-1];

    assign len_arr[0] = '0;
    assign len_arr[1] = lens.pre_len;
    assign len_arr[2] = lens.blink_len;
    assign len_arr[3] = lens.close_len;
    assign len_arr[4] = lens.hold_len;
    assign len_arr[5] = lens.open_len;

    // Unused codes behave as idle
    assign cur_phase = (phase_reg > PH_OPEN) ? PH_IDLE : phase_reg;
    assign cur_cnt   = (phase_reg > PH_OPEN) ? '0 : cnt_reg;
    assign dec_cnt   = cur_cnt - cnt_t'(1);

    always_comb
    begin
        req_next    = req_reg | button_press;
        do_enter    = 1'b0;
        start_phase = PH_IDLE;
        cnt_upd     = cur_cnt;
        if (cur_phase == PH_IDLE)
        begin
            if (req_next)
            begin
                req_next    = 1'b0;
                do_enter    = 1'b1;
                start_phase = PH_PRE;
            end
        end
        else if (second_tick)
        begin
            cnt_upd = dec_cnt;
            if (dec_cnt == '0)
            begin
                do_enter    = 1'b1;
                start_phase = (cur_phase == PH_OPEN) ? PH_IDLE : cur_phase + 3'd1;
            end
        end
    end

    // First phase from the start point with a non-zero length; none means idle
    always_comb
    begin
        sel_phase = PH_IDLE;
        sel_len   = '0;
        for (int p = NUM_PHASES - 1; p >= 1; p--)
        begin
            if (start_phase != PH_IDLE && 3'(p) >= start_phase && len_arr[p] != '0)
            begin
                sel_phase = 3'(p);
                sel_len   = len_arr[p];
            end
        end
    end

    always_comb
    begin
        phase_next = cur_phase;
        cnt_next   = cnt_upd;
        if (do_enter)
        begin
            phase_next = sel_phase;
            cnt_next   = sel_len;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= '0;
            req_reg   <= 1'b0;
        end
        else if (in_acc)
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            req_reg   <= req_next;
        end
    end

    // Lamp and motor decode of the post-update state
    always_comb
    begin
        result = '0;
        result.phase = phase_next;
        unique case (phase_next)
            PH_PRE:   result.green_lamp = 1'b1;
            PH_BLINK: result.orange_lamp = ~cnt_next[0];
            PH_CLOSE:
            begin
                result.red_lamp    = 1'b1;
                result.motor_close = 1'b1;
            end
            PH_HOLD:  result.red_lamp = 1'b1;
            PH_OPEN:
            begin
                result.red_lamp   = 1'b1;
                result.motor_open = 1'b1;
            end
            default:  result.green_lamp = 1'b1;
        endcase
    end

    `PCS_ASSERT_NOW(a_phase_legal, 1'b1, phase_reg <= PH_OPEN, "phase register out of range")
    `PCS_ASSERT_NOW(a_busy_count, phase_reg != PH_IDLE, cnt_reg != '0, "active phase with no ticks left")
    `PCS_ASSERT_NEXT(a_hold_state, !in_acc, $stable(phase_reg) && $stable(cnt_reg), "state moved without a request")

endmodule

// ----- hw/rtl/pcs_out.sv -----
// ----------------------------------------------------------------------------
// Pedestrian crossing sequencer - result stage
// Output register with a skid entry so input acceptance survives a stall.
// ----------------------------------------------------------------------------
`include "pedestrian_crossing_sequencer_unit_macros.svh"

module pcs_out
    import pcs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_acc,
    input  pcs_result_t result,
    input  logic        out_stall,
    output logic        out_valid,
    output logic        full,
    output pcs_result_t out_data
);

    logic        out_valid_reg;
    logic        skid_valid_reg;
    pcs_result_t out_data_reg;
    pcs_result_t skid_data_reg;
    logic        take;

    assign take      = out_valid_reg & ~out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign full      = skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            // Drain the skid entry into the output register
            if (take)
                skid_valid_reg <= 1'b0;
        end
        else if (in_acc)
        begin
            if (!out_valid_reg || take)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
                out_data_reg <= skid_data_reg;
        end
        else if (in_acc)
        begin
            if (!out_valid_reg || take)
                out_data_reg <= result;
            else
                skid_data_reg <= result;
        end
    end

    `PCS_ASSERT_NOW(a_skid_behind_out, skid_valid_reg, out_valid_reg, "skid entry ahead of output")
    `PCS_ASSERT_NOW(a_no_accept_full, skid_valid_reg, !in_acc, "request taken with both entries full")
    `PCS_ASSERT_NEXT(a_skid_holds, skid_valid_reg && out_stall, skid_valid_reg && $stable(skid_data_reg), "skid entry lost under stall")

endmodule

// ----- hw/rtl/pedestrian_crossing_sequencer_unit.sv -----
// ----------------------------------------------------------------------------
// Pedestrian crossing sequencer unit - top level
// Lamp and barrier sequencing on button requests and one-second ticks.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+-------------------------------------------
//  in      | in_valid/in_stall  | button_press, second_tick
//  out     | out_valid/out_stall| green_lamp, orange_lamp, red_lamp,
//          |                    | motor_close, motor_open, phase
//  cfg     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
//  One request per cycle unless stalled; its result is registered in the output
//  register, or the skid entry on a stall. The phase register and tick counter
//  update in the accepting cycle. Reset gives idle, no pending press, default
//  phase lengths. An output stall fills the output register and then a skid
//  entry; in_stall rises only once both are occupied. cfg_ready is always high.
// ----------------------------------------------------------------------------
module pedestrian_crossing_sequencer_unit
    import pcs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       button_press,
    input  logic       second_tick,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       green_lamp,
    output logic       orange_lamp,
    output logic       red_lamp,
    output logic       motor_close,
    output logic       motor_open,
    output logic [2:0] phase,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data
);

    pcs_len_t    lens;
    pcs_result_t result;
    pcs_result_t out_data;
    logic        in_acc;
    logic        full;

    assign cfg_ready = 1'b1;
    assign in_stall  = full;
    assign in_acc    = in_valid & ~full;

    pcs_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .lens      (lens)
    );

    pcs_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_acc       (in_acc),
        .button_press (button_press),
        .second_tick  (second_tick),
        .lens         (lens),
        .result       (result)
    );

    pcs_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_acc    (in_acc),
        .result    (result),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .full      (full),
        .out_data  (out_data)
    );

    assign green_lamp  = out_data.green_lamp;
    assign orange_lamp = out_data.orange_lamp;
    assign red_lamp    = out_data.red_lamp;
    assign motor_close = out_data.motor_close;
    assign motor_open  = out_data.motor_open;
    assign phase       = out_data.phase;

endmodule
